// ----- hw/rtl/jsu_pkg.sv -----
// Shared types for the JSON string unescaper: result status codes and the decoded result group.
`default_nettype none

package jsu_pkg;

   // Most UTF-8 bytes one input byte can produce
   localparam int unsigned MaxBytes = 4;

   typedef enum logic [1:0] {
      STATUS_DATA  = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   // All results caused by one input byte; status results always travel alone
   typedef struct packed {
      logic [2:0]                count;
      logic [MaxBytes-1:0][7:0]  bytes;
      logic                      byte_valid;
      status_type                status;
   } group_type;

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_req_if.sv -----
// Input byte channel of the JSON string unescaper.
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_buffer;

   modport source (output valid, output in_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/jsu_rsp_if.sv -----
// Result channel of the JSON string unescaper.
`default_nettype none

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output status,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input status,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/jsu_decode.sv -----
// Escape decoder: parser state, hex gathering, surrogate pairing and UTF-8 encoding.
`default_nettype none

module jsu_decode (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    in_byte,
   input  wire logic          end_of_buffer,
   output jsu_pkg::group_type group
);
   import jsu_pkg::*;

   typedef enum logic [6:0] {
      MODE_WAIT  = 7'b0000001,
      MODE_BODY  = 7'b0000010,
      MODE_ESC   = 7'b0000100,
      MODE_HEXHI = 7'b0001000,
      MODE_SBS   = 7'b0010000,
      MODE_SU    = 7'b0100000,
      MODE_HEXLO = 7'b1000000
   } mode_type;

   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChB      = 8'h62;
   localparam logic [7:0] ChF      = 8'h66;
   localparam logic [7:0] ChN      = 8'h6E;
   localparam logic [7:0] ChR      = 8'h72;
   localparam logic [7:0] ChT      = 8'h74;
   localparam logic [7:0] ChU      = 8'h75;

   // {ok, value}
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

   mode_type    mode_ff, mode_in;
   logic [15:0] accum_ff, accum_in;
   logic [9:0]  high_ff, high_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;

   logic [4:0]  hex;
   logic [15:0] acc_shift;
   logic        hex_full;
   logic [20:0] low_sum;
   logic [20:0] code_point;
   logic        emit_cp;
   logic        emit_plain;
   logic [7:0]  plain_byte;
   logic        bad;
   logic        done;
   logic        fail;
   logic [2:0]  cp_count;
   logic [MaxBytes-1:0][7:0] cp_bytes;

   assign hex       = hex_val(in_byte);
   assign acc_shift = {accum_ff[11:0], hex[3:0]};
   assign hex_full  = (hex_cnt_ff == 2'd3);
   // 0x10000 + (high << 10) + (low - 0xDC00)
   assign low_sum   = {1'b0, high_ff, acc_shift[9:0]} + 21'h10000;

   always_comb begin
      mode_in    = mode_ff;
      accum_in   = accum_ff;
      high_in    = high_ff;
      hex_cnt_in = hex_cnt_ff;
      bad        = 1'b0;
      done       = 1'b0;
      emit_plain = 1'b0;
      plain_byte = in_byte;
      emit_cp    = 1'b0;
      code_point = {5'd0, acc_shift};

      unique case (mode_ff)
         MODE_BODY: begin
            if (in_byte == ChQuote)       done = 1'b1;
            else if (in_byte == ChBslash) mode_in = MODE_ESC;
            else                          emit_plain = 1'b1;
         end
         MODE_ESC: begin
            mode_in = MODE_BODY;
            unique case (in_byte)
               ChQuote, ChBslash, ChSlash: emit_plain = 1'b1;
               ChB: begin emit_plain = 1'b1; plain_byte = 8'h08; end
               ChF: begin emit_plain = 1'b1; plain_byte = 8'h0C; end
               ChN: begin emit_plain = 1'b1; plain_byte = 8'h0A; end
               ChR: begin emit_plain = 1'b1; plain_byte = 8'h0D; end
               ChT: begin emit_plain = 1'b1; plain_byte = 8'h09; end
               ChU: begin
                  mode_in    = MODE_HEXHI;
                  accum_in   = 16'd0;
                  hex_cnt_in = 2'd0;
               end
               default: bad = 1'b1;
            endcase
         end
         MODE_HEXHI, MODE_HEXLO: begin
            if (!hex[4]) begin
               bad = 1'b1;
            end else begin
               accum_in   = acc_shift;
               hex_cnt_in = hex_cnt_ff + 2'd1;
               if (hex_full) begin
                  if (mode_ff == MODE_HEXHI) begin
                     if (acc_shift[15:10] == 6'b110110) begin
                        high_in = acc_shift[9:0];
                        mode_in = MODE_SBS;
                     end else begin
                        emit_cp = 1'b1;
                        mode_in = MODE_BODY;
                     end
                  end else if (acc_shift[15:10] != 6'b110111) begin
                     bad = 1'b1;
                  end else begin
                     emit_cp    = 1'b1;
                     code_point = low_sum;
                     mode_in    = MODE_BODY;
                  end
               end
            end
         end
         MODE_SBS: begin
            if (in_byte == ChBslash) mode_in = MODE_SU;
            else                     bad = 1'b1;
         end
         MODE_SU: begin
            if (in_byte == ChU) begin
               mode_in    = MODE_HEXLO;
               accum_in   = 16'd0;
               hex_cnt_in = 2'd0;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            if (in_byte == ChQuote) mode_in = MODE_BODY;
            else                    bad = 1'b1;
         end
      endcase

      // buffer running out anywhere but on the closing quote is an error
      fail = bad || (end_of_buffer && !done);

      if (fail || done) begin
         mode_in    = MODE_WAIT;
         accum_in   = 16'd0;
         high_in    = 10'd0;
         hex_cnt_in = 2'd0;
      end
   end

   // UTF-8 encoder
   always_comb begin
      cp_bytes = '0;
      if (code_point < 21'h80) begin
         cp_count    = 3'd1;
         cp_bytes[0] = code_point[7:0];
      end else if (code_point < 21'h800) begin
         cp_count    = 3'd2;
         cp_bytes[0] = {3'b110, code_point[10:6]};
         cp_bytes[1] = {2'b10, code_point[5:0]};
      end else if (code_point < 21'h10000) begin
         cp_count    = 3'd3;
         cp_bytes[0] = {4'b1110, code_point[15:12]};
         cp_bytes[1] = {2'b10, code_point[11:6]};
         cp_bytes[2] = {2'b10, code_point[5:0]};
      end else begin
         cp_count    = 3'd4;
         cp_bytes[0] = {5'b11110, code_point[20:18]};
         cp_bytes[1] = {2'b10, code_point[17:12]};
         cp_bytes[2] = {2'b10, code_point[11:6]};
         cp_bytes[3] = {2'b10, code_point[5:0]};
      end
   end

   always_comb begin
      group            = '0;
      group.byte_valid = 1'b0;
      group.status     = STATUS_DATA;
      priority if (fail) begin
         group.count  = 3'd1;
         group.status = STATUS_ERROR;
      end else if (done) begin
         group.count  = 3'd1;
         group.status = STATUS_DONE;
      end else if (emit_plain) begin
         group.count      = 3'd1;
         group.bytes[0]   = plain_byte;
         group.byte_valid = 1'b1;
      end else if (emit_cp) begin
         group.count      = cp_count;
         group.bytes      = cp_bytes;
         group.byte_valid = 1'b1;
      end else begin
         group.count = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WAIT;
         accum_ff   <= 16'd0;
         high_ff    <= 10'd0;
         hex_cnt_ff <= 2'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         accum_ff   <= accum_in;
         high_ff    <= high_in;
         hex_cnt_ff <= hex_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8.sv -----
// Top level of the JSON string unescaper: decoder plus result group register and serializer.
//
//   channel | dir | payload                                 | transfer when
//   --------+-----+-----------------------------------------+------------------------
//   req     | in  | in_byte[7:0], end_of_buffer             | req.valid && req.ready
//   rsp     | out | out_byte[7:0], byte_valid, status, last | rsp.valid && rsp.ready
//
// A byte is decoded in the cycle of its transfer; its results land in the group register
//   and leave one per cycle while rsp is ready. A byte with more results holds req until
//   its last result leaves; bytes with at most one result pass one per cycle if rsp is ready.
// req.ready is high when the group register is empty or its last result transfers now.
// Reset clears the decoder to waiting for the opening quote and empties the group register.
// Stalls on rsp hold the current result; bytes with no results pass while rsp is idle.
`default_nettype none

module json_string_unescape_utf8 (
   input wire logic   clock,
   input wire logic   reset,
   jsu_req_if.sink    req,
   jsu_rsp_if.source  rsp
);
   import jsu_pkg::*;

   group_type                group;
   logic [2:0]               count_ff, count_in;
   logic [1:0]               idx_ff, idx_in;
   logic [MaxBytes-1:0][7:0] bytes_ff;
   logic                     byte_valid_ff;
   status_type               status_ff;
   logic                     req_xfer;
   logic                     rsp_xfer;
   logic                     rsp_last;
   logic                     load;

   // last result of the held group
   assign rsp_last = (({1'b0, idx_ff} + 3'd1) == count_ff);
   assign rsp_xfer = rsp.valid && rsp.ready;

   // take a new byte when the group register is empty or while the final result of the previous one is leaving
   assign req.ready = (count_ff == 3'd0) || (rsp.ready && rsp_last);
   assign req_xfer  = req.valid && req.ready;
   assign load      = req_xfer && (group.count != 3'd0);

   jsu_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_xfer),
      .in_byte       (req.in_byte),
      .end_of_buffer (req.end_of_buffer),
      .group         (group)
   );

   always_comb begin
      priority if (load) begin
         count_in = group.count;
         idx_in   = 2'd0;
      end else if (rsp_xfer) begin
         if (rsp_last) begin
            count_in = 3'd0;
            idx_in   = 2'd0;
         end else begin
            count_in = count_ff;
            idx_in   = idx_ff + 2'd1;
         end
      end else begin
         count_in = count_ff;
         idx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff      <= group.bytes;
         byte_valid_ff <= group.byte_valid;
         status_ff     <= group.status;
      end
   end

   assign rsp.valid      = (count_ff != 3'd0);
   assign rsp.out_byte   = bytes_ff[idx_ff];
   assign rsp.byte_valid = byte_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.last       = rsp_last;

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(MaxBytes))
      else $error("result group count out of range");

   a_idx_in_group : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ({1'b0, idx_ff} < count_ff))
      else $error("result index beyond group");

   a_status_alone : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.byte_valid |-> rsp.last && (idx_ff == 2'd0))
      else $error("status result not alone in its group");

   a_valid_matches_status : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.byte_valid == (rsp.status == STATUS_DATA)))
      else $error("byte_valid disagrees with status");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      req_xfer && (count_ff != 3'd0) |-> rsp_xfer && rsp_last)
      else $error("new byte accepted over pending results");
`endif

endmodule

`default_nettype wire
